>>> rtl/core/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Shared types, grouping tables and codes for the glyph 8x16 to 5x6 downscaler.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int NUM_COLS  = 8;
    localparam int NUM_ROWS  = 16;
    localparam int OUT_ROWS  = 6;
    localparam int OUT_COLS  = 5;

    localparam logic [7:0] SPARSE_LIMIT_RESET = 8'd54;
    localparam logic [7:0] DENSE_LIMIT_RESET  = 8'd85;

    // register indexes on the config port
    localparam logic CFG_SPARSE_LIMIT = 1'b0;
    localparam logic CFG_DENSE_LIMIT  = 1'b1;

    typedef logic [2:0] cell_cnt_t;   // up to 6 pixels per cell
    typedef logic [4:0] row_sum_t;    // up to 24 pixels per row band
    typedef logic [7:0] pix_cnt_t;    // up to 128 pixels per glyph
    typedef logic [4:0] row_mask_t;   // bit 4 is the leftmost cell

    typedef enum logic [1:0] {
        METHOD_BOX    = 2'd0,
        METHOD_SPARSE = 2'd1,
        METHOD_DENSE  = 2'd2
    } method_t;

    // source row (0 = top) to output row
    localparam logic [2:0] ROW_GROUP [NUM_ROWS] =
        '{3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
          3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5};

    // source column to output column
    localparam logic [2:0] COL_GROUP [NUM_COLS] =
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4};

    localparam cell_cnt_t CELL_THRESH [OUT_ROWS][OUT_COLS] = '{
        '{3'd3, 3'd2, 3'd3, 3'd3, 3'd2},
        '{3'd3, 3'd2, 3'd3, 3'd3, 3'd2},
        '{3'd2, 3'd1, 3'd2, 3'd2, 3'd1},
        '{3'd2, 3'd1, 3'd2, 3'd2, 3'd1},
        '{3'd3, 3'd2, 3'd3, 3'd3, 3'd2},
        '{3'd3, 3'd2, 3'd3, 3'd3, 3'd2}
    };

    // pixels covered by each cell
    localparam cell_cnt_t CELL_SIZE [OUT_ROWS][OUT_COLS] = '{
        '{3'd6, 3'd3, 3'd6, 3'd6, 3'd3},
        '{3'd6, 3'd3, 3'd6, 3'd6, 3'd3},
        '{3'd4, 3'd2, 3'd4, 3'd4, 3'd2},
        '{3'd4, 3'd2, 3'd4, 3'd4, 3'd2},
        '{3'd6, 3'd3, 3'd6, 3'd6, 3'd3},
        '{3'd6, 3'd3, 3'd6, 3'd6, 3'd3}
    };

endpackage

>>> rtl/core/glyph_8x16_to_5x6_downscaler.sv
// Throughput: one glyph per cycle; four register stages (cell counts, band sums
// and cell flags, pixel total, method select and output).
// busy is always low and done is a one-cycle strobe; the receiver cannot stall.
// Reset clears all valid bits and loads sparse_limit = 54, dense_limit = 85.
// ----------------------------------------------------------------------------
// glyph_8x16_to_5x6_downscaler
// Reduces an 8x16 glyph to 5x6 by box filter, sparse OR or dense AND per cell.
// ----------------------------------------------------------------------------
module glyph_8x16_to_5x6_downscaler
    import gds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [6:0]  glyph_index,
    input  logic [15:0] column_0,
    input  logic [15:0] column_1,
    input  logic [15:0] column_2,
    input  logic [15:0] column_3,
    input  logic [15:0] column_4,
    input  logic [15:0] column_5,
    input  logic [15:0] column_6,
    input  logic [15:0] column_7,
    output logic        done,
    output logic [6:0]  out_index,
    output logic [7:0]  row_0,
    output logic [7:0]  row_1,
    output logic [7:0]  row_2,
    output logic [7:0]  row_3,
    output logic [7:0]  row_4,
    output logic [7:0]  row_5,
    output logic [1:0]  method_used
);

    logic [7:0]  sparse_limit_reg;
    logic [7:0]  dense_limit_reg;
    logic [15:0] colw [NUM_COLS];
    logic        accept;

    // stage 1: cell counts
    logic        s1_valid_reg;
    logic [6:0]  s1_index_reg;
    cell_cnt_t   s1_cnt_reg  [OUT_ROWS][OUT_COLS];
    cell_cnt_t   s1_cnt_next [OUT_ROWS][OUT_COLS];

    // stage 2: band sums and per-cell flags
    logic        s2_valid_reg;
    logic [6:0]  s2_index_reg;
    row_sum_t    s2_sum_reg  [OUT_ROWS];
    row_sum_t    s2_sum_next [OUT_ROWS];
    row_mask_t   s2_box_reg  [OUT_ROWS];
    row_mask_t   s2_any_reg  [OUT_ROWS];
    row_mask_t   s2_all_reg  [OUT_ROWS];
    row_mask_t   s2_box_next [OUT_ROWS];
    row_mask_t   s2_any_next [OUT_ROWS];
    row_mask_t   s2_all_next [OUT_ROWS];

    // stage 3: pixel total
    logic        s3_valid_reg;
    logic [6:0]  s3_index_reg;
    pix_cnt_t    s3_count_reg;
    pix_cnt_t    s3_count_next;
    row_mask_t   s3_box_reg  [OUT_ROWS];
    row_mask_t   s3_any_reg  [OUT_ROWS];
    row_mask_t   s3_all_reg  [OUT_ROWS];

    // stage 4: output
    logic        done_reg;
    logic [6:0]  out_index_reg;
    row_mask_t   out_mask_reg  [OUT_ROWS];
    row_mask_t   out_mask_next [OUT_ROWS];
    method_t     method_reg;
    method_t     method_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign colw[0] = column_0;
    assign colw[1] = column_1;
    assign colw[2] = column_2;
    assign colw[3] = column_3;
    assign colw[4] = column_4;
    assign colw[5] = column_5;
    assign colw[6] = column_6;
    assign colw[7] = column_7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sparse_limit_reg <= SPARSE_LIMIT_RESET;
            dense_limit_reg  <= DENSE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPARSE_LIMIT: sparse_limit_reg <= cfg_wdata;
                CFG_DENSE_LIMIT:  dense_limit_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- stage 1 ----
    always_comb
    begin
        for (int r = 0; r < OUT_ROWS; r++)
        begin
            for (int g = 0; g < OUT_COLS; g++)
            begin
                s1_cnt_next[r][g] = '0;
                for (int t = 0; t < NUM_ROWS; t++)
                begin
                    for (int c = 0; c < NUM_COLS; c++)
                    begin
                        if (ROW_GROUP[t] == 3'(r) && COL_GROUP[c] == 3'(g))
                        begin
                            s1_cnt_next[r][g] = s1_cnt_next[r][g]
                                + cell_cnt_t'(colw[c][NUM_ROWS - 1 - t]);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_index_reg <= glyph_index;
            s1_cnt_reg   <= s1_cnt_next;
        end
    end

    // ---- stage 2 ----
    always_comb
    begin
        for (int r = 0; r < OUT_ROWS; r++)
        begin
            s2_sum_next[r] = '0;
            for (int g = 0; g < OUT_COLS; g++)
            begin
                s2_sum_next[r] = s2_sum_next[r] + row_sum_t'(s1_cnt_reg[r][g]);
                s2_box_next[r][OUT_COLS - 1 - g] = s1_cnt_reg[r][g] >= CELL_THRESH[r][g];
                s2_any_next[r][OUT_COLS - 1 - g] = s1_cnt_reg[r][g] != '0;
                s2_all_next[r][OUT_COLS - 1 - g] = s1_cnt_reg[r][g] == CELL_SIZE[r][g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_index_reg <= s1_index_reg;
            s2_sum_reg   <= s2_sum_next;
            s2_box_reg   <= s2_box_next;
            s2_any_reg   <= s2_any_next;
            s2_all_reg   <= s2_all_next;
        end
    end

    // ---- stage 3 ----
    always_comb
    begin
        s3_count_next = '0;
        for (int r = 0; r < OUT_ROWS; r++)
            s3_count_next = s3_count_next + pix_cnt_t'(s2_sum_reg[r]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_index_reg <= s2_index_reg;
            s3_count_reg <= s3_count_next;
            s3_box_reg   <= s2_box_reg;
            s3_any_reg   <= s2_any_reg;
            s3_all_reg   <= s2_all_reg;
        end
    end

    // ---- stage 4 ----
    // crossed limits fall to dense when the count reaches dense_limit
    always_comb
    begin
        if (sparse_limit_reg <= s3_count_reg && s3_count_reg < dense_limit_reg)
            method_next = METHOD_BOX;
        else if (s3_count_reg >= dense_limit_reg)
            method_next = METHOD_DENSE;
        else
            method_next = METHOD_SPARSE;

        for (int r = 0; r < OUT_ROWS; r++)
        begin
            case (method_next)
                METHOD_BOX:    out_mask_next[r] = s3_box_reg[r];
                METHOD_SPARSE: out_mask_next[r] = s3_any_reg[r];
                METHOD_DENSE:  out_mask_next[r] = s3_all_reg[r];
                default:       out_mask_next[r] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            out_index_reg <= s3_index_reg;
            out_mask_reg  <= out_mask_next;
            method_reg    <= method_next;
        end
    end

    assign done        = done_reg;
    assign out_index   = out_index_reg;
    assign row_0       = {out_mask_reg[0], 3'b000};
    assign row_1       = {out_mask_reg[1], 3'b000};
    assign row_2       = {out_mask_reg[2], 3'b000};
    assign row_3       = {out_mask_reg[3], 3'b000};
    assign row_4       = {out_mask_reg[4], 3'b000};
    assign row_5       = {out_mask_reg[5], 3'b000};
    assign method_used = method_reg;

    // ---- assertions ----
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("glyph did not reach the output after four cycles");

    a_index_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 (out_index == $past(glyph_index, 4)))
        else $error("font slot changed on its way through the pipeline");

    a_all_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ((s2_all_reg[0] & ~s2_any_reg[0]) == '0 &&
                          (s2_all_reg[2] & ~s2_any_reg[2]) == '0 &&
                          (s2_all_reg[5] & ~s2_any_reg[5]) == '0))
        else $error("full cell flagged without any set pixel");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_count_reg <= pix_cnt_t'(NUM_COLS * NUM_ROWS)))
        else $error("pixel total exceeds glyph size");

endmodule

>>> bench/glyph_8x16_to_5x6_downscaler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_8x16_to_5x6_downscaler_tb
// Self-checking bench for the 8x16 to 5x6 glyph downscaler. Glyphs go in by
// start/busy, each accepted glyph is reduced by an in-bench model and the
// expected rows are queued, and every done strobe is checked in order. The run
// steps through several limit settings (crossed and out-of-range ones too)
// with different amounts of idling on the start side.
// ----------------------------------------------------------------------------
module glyph_8x16_to_5x6_downscaler_tb
    import gds_pkg::*;
;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_GLYPHS = 135;
    localparam int NUM_PHASES   = 8;

    // source row / column to output cell, top to bottom and left to right
    localparam int ROW_BAND [16] = '{0, 0, 0, 1, 1, 1, 2, 2, 3, 3, 4, 4, 4, 5, 5, 5};
    localparam int COL_BAND [8]  = '{0, 0, 1, 2, 2, 3, 3, 4};
    localparam int BOX_LEVEL [6][5] = '{
        '{3, 2, 3, 3, 2},
        '{3, 2, 3, 3, 2},
        '{2, 1, 2, 2, 1},
        '{2, 1, 2, 2, 1},
        '{3, 2, 3, 3, 2},
        '{3, 2, 3, 3, 2}
    };

    // limit settings per phase; idle percentage cycles through the list
    localparam logic [7:0] PHASE_SPARSE [NUM_PHASES] =
        '{8'd0, 8'd129, 8'd0, 8'd129, 8'd100, 8'd30, 8'd64, 8'd54};
    localparam logic [7:0] PHASE_DENSE [NUM_PHASES] =
        '{8'd0, 8'd129, 8'd129, 8'd0, 8'd40, 8'd100, 8'd65, 8'd85};
    localparam int IDLE_PCT [3] = '{0, 65, 20};

    typedef struct packed {
        logic [6:0]       idx;
        logic [7:0][15:0] cols;
    } glyph_t;

    typedef struct packed {
        logic [6:0]      idx;
        logic [5:0][7:0] rows;
        method_t         method;
    } rows_t;

    class glyph_scoreboard;
        rows_t      expected_rows[$];
        logic [7:0] sparse_lim;
        logic [7:0] dense_lim;
        int         errors;

        function new();
            sparse_lim = SPARSE_LIMIT_RESET;
            dense_lim  = DENSE_LIMIT_RESET;
            errors     = 0;
        endfunction

        function void set_limits(logic [7:0] s, logic [7:0] d);
            sparse_lim = s;
            dense_lim  = d;
        endfunction

        function rows_t downscale(glyph_t g);
            int    lit_n [6][5];
            int    dark_n [6][5];
            int    total;
            bit    on;
            rows_t r;
            total = 0;
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 5; j++)
                begin
                    lit_n[i][j]  = 0;
                    dark_n[i][j] = 0;
                end
            for (int c = 0; c < 8; c++)
                for (int t = 0; t < 16; t++)
                begin
                    if (g.cols[c][15 - t])
                    begin
                        total++;
                        lit_n[ROW_BAND[t]][COL_BAND[c]]++;
                    end
                    else
                        dark_n[ROW_BAND[t]][COL_BAND[c]]++;
                end
            if (sparse_lim <= total && total < dense_lim)
                r.method = METHOD_BOX;
            else if (total >= dense_lim)
                r.method = METHOD_DENSE;
            else
                r.method = METHOD_SPARSE;
            r.idx  = g.idx;
            r.rows = '0;
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 5; j++)
                begin
                    case (r.method)
                        METHOD_BOX:    on = lit_n[i][j] >= BOX_LEVEL[i][j];
                        METHOD_SPARSE: on = lit_n[i][j] != 0;
                        default:       on = dark_n[i][j] == 0;
                    endcase
                    r.rows[i][7 - j] = on;
                end
            return r;
        endfunction

        function void note_glyph(glyph_t g);
            expected_rows.push_back(downscale(g));
        endfunction

        function void check_rows(rows_t got);
            rows_t want;
            if (expected_rows.size() == 0)
            begin
                $display("%0t: unexpected word: index %h method %0d",
                         $time, got.idx, got.method);
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            if (got.idx !== want.idx)
            begin
                $display("%0t: out_index expected %h actual %h", $time, want.idx, got.idx);
                errors++;
            end
            for (int i = 0; i < 6; i++)
                if (got.rows[i] !== want.rows[i])
                begin
                    $display("%0t: slot %h row_%0d expected %h actual %h",
                             $time, want.idx, i, want.rows[i], got.rows[i]);
                    errors++;
                end
            if (got.method !== want.method)
            begin
                $display("%0t: slot %h method_used expected %0d actual %0d",
                         $time, want.idx, want.method, got.method);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    logic        start;
    logic        busy;
    logic [6:0]  glyph_index;
    logic [15:0] column_0;
    logic [15:0] column_1;
    logic [15:0] column_2;
    logic [15:0] column_3;
    logic [15:0] column_4;
    logic [15:0] column_5;
    logic [15:0] column_6;
    logic [15:0] column_7;
    logic        done;
    logic [6:0]  out_index;
    logic [7:0]  row_0;
    logic [7:0]  row_1;
    logic [7:0]  row_2;
    logic [7:0]  row_3;
    logic [7:0]  row_4;
    logic [7:0]  row_5;
    logic [1:0]  method_used;

    glyph_scoreboard sb;
    int              cycle_count;

    glyph_8x16_to_5x6_downscaler uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .glyph_index (glyph_index),
        .column_0    (column_0),
        .column_1    (column_1),
        .column_2    (column_2),
        .column_3    (column_3),
        .column_4    (column_4),
        .column_5    (column_5),
        .column_6    (column_6),
        .column_7    (column_7),
        .done        (done),
        .out_index   (out_index),
        .row_0       (row_0),
        .row_1       (row_1),
        .row_2       (row_2),
        .row_3       (row_3),
        .row_4       (row_4),
        .row_5       (row_5),
        .method_used (method_used)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[glyph_8x16_to_5x6_downscaler] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_rows('{idx: out_index,
                            rows: {row_5, row_4, row_3, row_2, row_1, row_0},
                            method: method_t'(method_used)});
    end

    task automatic drive_fields(glyph_t g);
        glyph_index <= g.idx;
        column_0    <= g.cols[0];
        column_1    <= g.cols[1];
        column_2    <= g.cols[2];
        column_3    <= g.cols[3];
        column_4    <= g.cols[4];
        column_5    <= g.cols[5];
        column_6    <= g.cols[6];
        column_7    <= g.cols[7];
    endtask

    // idle cycles carry random junk on the fields with start low
    task automatic send_glyph(glyph_t g, int idle_pct);
        glyph_t junk;
        while ($urandom_range(99) < idle_pct)
        begin
            junk.idx  = 7'($urandom);
            junk.cols = {$urandom, $urandom, $urandom, $urandom};
            start <= 1'b0;
            drive_fields(junk);
            @(posedge clk);
        end
        start <= 1'b1;
        drive_fields(g);
        do
            @(posedge clk);
        while (busy);
        sb.note_glyph(g);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(logic [7:0] s, logic [7:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARSE_LIMIT;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_index <= CFG_DENSE_LIMIT;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limits(s, d);
    endtask

    // exactly n set pixels at random places
    function automatic glyph_t glyph_with_count(logic [6:0] idx, int n);
        glyph_t g;
        int     have;
        int     c;
        int     t;
        g.idx  = idx;
        g.cols = '0;
        have   = 0;
        if (n > 128)
            n = 128;
        while (have < n)
        begin
            c = $urandom_range(7);
            t = $urandom_range(15);
            if (!g.cols[c][t])
            begin
                g.cols[c][t] = 1'b1;
                have++;
            end
        end
        return g;
    endfunction

    function automatic glyph_t random_glyph();
        glyph_t g;
        int     pick;
        int     density;
        int     n;
        pick = $urandom_range(9);
        g.idx = $urandom_range(127);
        if (pick < 2)
            g.cols = {$urandom, $urandom, $urandom, $urandom};
        else if (pick < 6)
        begin
            density = $urandom_range(100);
            for (int c = 0; c < 8; c++)
                for (int t = 0; t < 16; t++)
                    g.cols[c][t] = $urandom_range(99) < density;
        end
        else if (pick < 9)
        begin
            // land on or next to one of the current limits
            n = ($urandom_range(1) ? sb.sparse_lim : sb.dense_lim) + $urandom_range(4) - 2;
            if (n < 0)
                n = 0;
            g = glyph_with_count(g.idx, n);
        end
        else
            g = glyph_with_count(g.idx, $urandom_range(1) ? $urandom_range(6)
                                                           : $urandom_range(128, 122));
        return g;
    endfunction

    initial
    begin
        sb          = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_SPARSE_LIMIT;
        cfg_wdata   = '0;
        start       = 1'b0;
        glyph_index = '0;
        column_0    = '0;
        column_1    = '0;
        column_2    = '0;
        column_3    = '0;
        column_4    = '0;
        column_5    = '0;
        column_6    = '0;
        column_7    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset limits
        send_glyph('{idx: 7'd0, cols: '0}, 0);
        send_glyph('{idx: 7'd127, cols: {8{16'hFFFF}}}, 0);
        send_glyph('{idx: 7'd5, cols: {{7{16'h0000}}, 16'h8000}}, 0);
        send_glyph('{idx: 7'd6, cols: {16'h0001, {7{16'h0000}}}}, 0);
        // dense with one hole
        send_glyph('{idx: 7'd7, cols: {{4{16'hFFFF}}, 16'hFFF7, {3{16'hFFFF}}}}, 0);
        send_glyph('{idx: 7'd8, cols: {4{16'hAAAA, 16'h5555}}}, 0);
        send_glyph('{idx: 7'd9, cols: {8{16'hE000}}}, 0);
        send_glyph('{idx: 7'd10, cols: {16'h0, 16'h0, 16'hFFFF, 16'h0,
                                        16'h0, 16'hFFFF, 16'h0, 16'hFFFF}}, 0);
        send_glyph(glyph_with_count(7'd11, 53), 0);
        send_glyph(glyph_with_count(7'd12, 54), 0);
        send_glyph(glyph_with_count(7'd13, 84), 0);
        send_glyph(glyph_with_count(7'd14, 85), 0);
        send_glyph(glyph_with_count(7'd15, 60), 0);
        send_glyph(glyph_with_count(7'd16, 70), 0);
        send_glyph(glyph_with_count(7'd17, 127), 0);
        send_glyph(glyph_with_count(7'd18, 1), 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_limits(PHASE_SPARSE[p], PHASE_DENSE[p]);
            repeat (PHASE_GLYPHS) send_glyph(random_glyph(), IDLE_PCT[p % 3]);
        end
        drain();

        if (sb.errors == 0 && sb.expected_rows.size() == 0)
            $display("[glyph_8x16_to_5x6_downscaler] OK");
        else
            $display("[glyph_8x16_to_5x6_downscaler] ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/gds_pkg.sv
rtl/core/glyph_8x16_to_5x6_downscaler.sv
bench/glyph_8x16_to_5x6_downscaler_tb.sv
